@@ rtl/core/rsait_pkg.sv @@
// Shared constants and types for the run/stop active/idle mode timer.
`timescale 1ns / 1ps

package rsait_pkg;

  // Configuration register width and APB port geometry
  localparam int CFG_W  = 21;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Stream payload widths
  localparam int IN_W   = 8;
  localparam int SEC_W  = 11;
  localparam int CNT_W  = 32;
  localparam int OUT_W  = 48;

  // Register map, index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_ACTIVE_DUR = 2'd0,
    REG_IDLE_DUR   = 2'd1,
    REG_START_LOCK = 2'd2,
    REG_PRESS_LOCK = 2'd3
  } cfg_reg_t;

  // Register reset values
  localparam logic [CFG_W-1:0] ACTIVE_DUR_RST = 21'd10000;
  localparam logic [CFG_W-1:0] IDLE_DUR_RST   = 21'd15000;
  localparam logic [CFG_W-1:0] START_LOCK_RST = 21'd200;
  localparam logic [CFG_W-1:0] PRESS_LOCK_RST = 21'd50;

  // Seconds rounding: ceil(ms / 1000) = ((ms + 999) * RECIP) >> SHIFT
  localparam int SUM_W     = CFG_W + 1;
  localparam int RECIP_W   = 23;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam int SEC_SHIFT = 32;
  localparam int QUOT_W    = 13;
  localparam logic [SUM_W-1:0]   SEC_ROUND = 22'd999;
  localparam logic [RECIP_W-1:0] SEC_RECIP = 23'd4294968;
  localparam logic [QUOT_W-1:0]  SEC_MAX_Q = 13'd2047;
  localparam logic [SEC_W-1:0]   SEC_MAX   = 11'd2047;

endpackage

@@ rtl/core/run_stop_active_idle_mode_timer_top.sv @@
// Run/stop timer with alternating active and idle modes, one tick per transfer.
`timescale 1ns / 1ps

//  channel  | ports                         | carries
//  ---------+-------------------------------+-----------------------------------------
//  in       | in_tvalid/in_tready/in_tdata  | one 1 ms tick: start level, press edge
//  out      | out_tvalid/out_tready/out_tdata | run, mode, LED, seconds left, press count
//  cfg      | cfg_psel..cfg_prdata (APB)    | durations and lockouts, 4 x 32-bit words
//
//  One tick per clock sustained while out_tready stays high. An input transfer
//  updates the timer state and the remaining milliseconds; the result stage then
//  rounds to seconds through one 22x23 multiply into the output register.
//  rst_n is synchronous, active low; the state, config and valid registers reset.
//  A stalled output holds; input keeps flowing while the result stage has room.

module run_stop_active_idle_mode_timer_top #(
  parameter int TIME_BITS = 21
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // tick stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [0] start_level, [1] press_edge, [7:2] zero
  input  logic [rsait_pkg::IN_W-1:0]    in_tdata,
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] is_running, [1] mode_is_idle, [2] led_on, [13:3] remaining_seconds,
  // [45:14] accepted_presses, [47:46] zero
  output logic [rsait_pkg::OUT_W-1:0]   out_tdata,
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rsait_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [rsait_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [rsait_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  localparam int CFG_W = rsait_pkg::CFG_W;
  localparam int CMPW  = (TIME_BITS > rsait_pkg::CFG_W) ? TIME_BITS : rsait_pkg::CFG_W;
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  // configuration registers
  logic [CFG_W-1:0] active_dur_r;
  logic [CFG_W-1:0] idle_dur_r;
  logic [CFG_W-1:0] start_lock_r;
  logic [CFG_W-1:0] press_lock_r;
  logic             cfg_wr;

  // timer state (also the first pipeline stage payload)
  logic                        run_r, run_nxt;
  logic                        idle_r, idle_nxt;
  logic                        led_r, led_nxt;
  logic                        prev_lvl_r, prev_lvl_nxt;
  logic                        pend_r, pend_nxt;
  logic [TIME_BITS-1:0]        mode_el_r, mode_el_nxt;
  logic [TIME_BITS-1:0]        start_el_r, start_el_nxt;
  logic [TIME_BITS-1:0]        press_el_r, press_el_nxt;
  logic [rsait_pkg::CNT_W-1:0] tot_r, tot_nxt;
  logic [CFG_W-1:0]            rem_ms_r, rem_ms_nxt;
  logic [CFG_W-1:0]            dur_sel;
  logic                        a_valid_r;

  // result stage
  logic                          out_valid_r;
  logic                          out_run_r;
  logic                          out_idle_r;
  logic                          out_led_r;
  logic [rsait_pkg::SEC_W-1:0]   out_secs_r;
  logic [rsait_pkg::CNT_W-1:0]   out_tot_r;

  logic                          in_fire;
  logic                          a_adv;
  logic                          lvl;
  logic                          edg;
  logic [rsait_pkg::SUM_W-1:0]   sec_sum;
  logic [rsait_pkg::PROD_W-1:0]  sec_prod;
  logic [rsait_pkg::QUOT_W-1:0]  sec_quot;
  logic [rsait_pkg::SEC_W-1:0]   secs;

  // ---------------------------------------------------------------- APB port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_dur_r <= rsait_pkg::ACTIVE_DUR_RST;
      idle_dur_r   <= rsait_pkg::IDLE_DUR_RST;
      start_lock_r <= rsait_pkg::START_LOCK_RST;
      press_lock_r <= rsait_pkg::PRESS_LOCK_RST;
    end else if (cfg_wr) begin
      case (rsait_pkg::cfg_reg_t'(cfg_paddr[3:2]))
        rsait_pkg::REG_ACTIVE_DUR: active_dur_r <= cfg_pwdata[CFG_W-1:0];
        rsait_pkg::REG_IDLE_DUR:   idle_dur_r   <= cfg_pwdata[CFG_W-1:0];
        rsait_pkg::REG_START_LOCK: start_lock_r <= cfg_pwdata[CFG_W-1:0];
        rsait_pkg::REG_PRESS_LOCK: press_lock_r <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // register read mux
  always_comb begin
    case (rsait_pkg::cfg_reg_t'(cfg_paddr[3:2]))
      rsait_pkg::REG_ACTIVE_DUR: cfg_prdata = rsait_pkg::DATA_W'(active_dur_r);
      rsait_pkg::REG_IDLE_DUR:   cfg_prdata = rsait_pkg::DATA_W'(idle_dur_r);
      rsait_pkg::REG_START_LOCK: cfg_prdata = rsait_pkg::DATA_W'(start_lock_r);
      rsait_pkg::REG_PRESS_LOCK: cfg_prdata = rsait_pkg::DATA_W'(press_lock_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  assign a_adv     = a_valid_r & (~out_valid_r | out_tready);
  assign in_tready = ~a_valid_r | a_adv;
  assign in_fire   = in_tvalid & in_tready;

  assign lvl = in_tdata[0];
  assign edg = in_tdata[1];

  // ---------------------------------------------------------------- tick update
  always_comb begin
    // elapsed counters advance, saturating
    mode_el_nxt  = (mode_el_r == TMAX) ? TMAX : mode_el_r + TIME_BITS'(1);
    start_el_nxt = (start_el_r == TMAX) ? TMAX : start_el_r + TIME_BITS'(1);
    press_el_nxt = (press_el_r == TMAX) ? TMAX : press_el_r + TIME_BITS'(1);
    run_nxt      = run_r;
    idle_nxt     = idle_r;
    led_nxt      = led_r;
    pend_nxt     = pend_r;
    tot_nxt      = tot_r;
    rem_ms_nxt   = '0;
    dur_sel      = '0;

    // press edge past its lockout
    if (edg && (CMPW'(press_el_nxt) > CMPW'(press_lock_r))) begin
      press_el_nxt = '0;
      tot_nxt      = tot_r + rsait_pkg::CNT_W'(1);
      pend_nxt     = 1'b1;
    end

    // start/stop falling edge past its lockout
    if (prev_lvl_r && !lvl && (CMPW'(start_el_nxt) >= CMPW'(start_lock_r))) begin
      start_el_nxt = '0;
      run_nxt      = ~run_r;
      if (run_r) begin
        led_nxt = 1'b0;
      end else begin
        idle_nxt    = 1'b0;
        mode_el_nxt = '0;
        pend_nxt    = 1'b0;
      end
    end
    prev_lvl_nxt = lvl;

    // mode switching and press consumption
    if (!run_nxt) begin
      pend_nxt = 1'b0;
    end else begin
      if (!idle_nxt && (CMPW'(mode_el_nxt) >= CMPW'(active_dur_r))) begin
        idle_nxt    = 1'b1;
        mode_el_nxt = '0;
        led_nxt     = 1'b1;
        pend_nxt    = 1'b0;
      end else if (idle_nxt && (CMPW'(mode_el_nxt) >= CMPW'(idle_dur_r))) begin
        idle_nxt    = 1'b0;
        mode_el_nxt = '0;
      end
      if (!idle_nxt && pend_nxt) begin
        pend_nxt = 1'b0;
        led_nxt  = ~led_nxt;
      end
      dur_sel = idle_nxt ? idle_dur_r : active_dur_r;
      if (CMPW'(mode_el_nxt) < CMPW'(dur_sel)) begin
        rem_ms_nxt = CFG_W'(CMPW'(dur_sel) - CMPW'(mode_el_nxt));
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r      <= 1'b0;
      idle_r     <= 1'b0;
      led_r      <= 1'b0;
      prev_lvl_r <= 1'b1;
      pend_r     <= 1'b0;
      mode_el_r  <= '0;
      start_el_r <= '0;
      press_el_r <= '0;
      tot_r      <= '0;
      a_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        run_r      <= run_nxt;
        idle_r     <= idle_nxt;
        led_r      <= led_nxt;
        prev_lvl_r <= prev_lvl_nxt;
        pend_r     <= pend_nxt;
        mode_el_r  <= mode_el_nxt;
        start_el_r <= start_el_nxt;
        press_el_r <= press_el_nxt;
        tot_r      <= tot_nxt;
      end
      if (in_fire) begin
        a_valid_r <= 1'b1;
      end else if (a_adv) begin
        a_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rem_ms_r <= rem_ms_nxt;
    end
  end

  // ---------------------------------------------------------------- seconds rounding
  assign sec_sum  = rsait_pkg::SUM_W'(rem_ms_r) + rsait_pkg::SEC_ROUND;
  assign sec_prod = rsait_pkg::PROD_W'(sec_sum) * rsait_pkg::PROD_W'(rsait_pkg::SEC_RECIP);
  assign sec_quot = sec_prod[rsait_pkg::SEC_SHIFT +: rsait_pkg::QUOT_W];
  assign secs     = (sec_quot > rsait_pkg::SEC_MAX_Q) ? rsait_pkg::SEC_MAX
                                                      : sec_quot[rsait_pkg::SEC_W-1:0];

  // ---------------------------------------------------------------- result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      out_run_r  <= run_r;
      out_idle_r <= idle_r;
      out_led_r  <= led_r;
      out_secs_r <= secs;
      out_tot_r  <= tot_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_tot_r, out_secs_r, out_led_r, out_idle_r, out_run_r};

`ifndef SYNTHESIS
  // stopped timer reports no time left
  assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !run_r) |-> (rem_ms_r == '0))
    else $error("remaining time nonzero while stopped");

  // no new tick taken while both stages are full and the output stalls
  assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("tick accepted into a full pipeline");

  // press count moves by at most one per cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (rsait_pkg::CNT_W'(tot_r - $past(tot_r)) <= rsait_pkg::CNT_W'(1)))
    else $error("press count jumped");

  // idle mode while running always has the LED on
  assert property (@(posedge clk) disable iff (!rst_n)
    (run_r && idle_r) |-> led_r)
    else $error("LED off during idle mode");
`endif

endmodule

@@ tb/run_stop_active_idle_mode_timer_checker.sv @@
// Scoreboard for the run/stop timer: tracks register writes, predicts each tick's report, compares.
`timescale 1ns / 1ps

module run_stop_active_idle_mode_timer_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [rsait_pkg::IN_W-1:0]   in_tdata,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [rsait_pkg::OUT_W-1:0]  out_tdata,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [rsait_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [rsait_pkg::DATA_W-1:0] cfg_pwdata,
  input  logic                         cfg_pready,
  output int                           errors,
  output int                           queued
);

  // Report layout, lowest bit last: matches out_tdata[45:0]
  typedef struct packed {
    logic [rsait_pkg::CNT_W-1:0] presses;
    logic [rsait_pkg::SEC_W-1:0] secs;
    logic                        led;
    logic                        idle;
    logic                        run;
  } timer_report_t;

  // Shadow of the timing registers
  logic [rsait_pkg::CFG_W-1:0] active_dur, idle_dur, start_lock, press_lock;

  // Shadow of the timer state
  logic                        running, idle, led, prev_level, press_pend;
  logic [rsait_pkg::CFG_W-1:0] mode_ms, start_ms, press_ms;
  logic [rsait_pkg::CNT_W-1:0] press_count;

  timer_report_t expected_reports[$];

  initial errors = 0;
  initial queued = 0;

  // Elapsed counters stick at all ones
  function automatic logic [rsait_pkg::CFG_W-1:0] sat_inc(
    input logic [rsait_pkg::CFG_W-1:0] v);
    return (v == '1) ? v : v + rsait_pkg::CFG_W'(1);
  endfunction

  // Advance the shadow state by one millisecond tick and form its report
  function automatic timer_report_t next_timer_report(input logic level, input logic pe);
    int unsigned   dur_ms;
    int unsigned   remain_ms;
    int unsigned   secs;
    timer_report_t r;
    mode_ms  = sat_inc(mode_ms);
    start_ms = sat_inc(start_ms);
    press_ms = sat_inc(press_ms);
    // press debounce: strictly more than the lockout
    if (pe && press_ms > press_lock) begin
      press_ms    = '0;
      press_count = press_count + rsait_pkg::CNT_W'(1);
      press_pend  = 1'b1;
    end
    // falling edge on the start/stop level toggles run state
    if (prev_level && !level && start_ms >= start_lock) begin
      start_ms = '0;
      running  = !running;
      if (!running) begin
        led = 1'b0;
      end else begin
        idle       = 1'b0;
        mode_ms    = '0;
        press_pend = 1'b0;
      end
    end
    prev_level = level;
    secs = 0;
    if (!running) begin
      press_pend = 1'b0;
    end else begin
      if (!idle && mode_ms >= active_dur) begin
        idle       = 1'b1;
        mode_ms    = '0;
        led        = 1'b1;
        press_pend = 1'b0;
      end else if (idle && mode_ms >= idle_dur) begin
        idle    = 1'b0;
        mode_ms = '0;
      end
      if (!idle && press_pend) begin
        press_pend = 1'b0;
        led        = !led;
      end
      dur_ms    = idle ? 32'(idle_dur) : 32'(active_dur);
      remain_ms = (32'(mode_ms) >= dur_ms) ? 0 : dur_ms - 32'(mode_ms);
      secs      = (remain_ms + 999) / 1000;
      if (secs > 32'(rsait_pkg::SEC_MAX)) secs = 32'(rsait_pkg::SEC_MAX);
    end
    r.run     = running;
    r.idle    = idle;
    r.led     = led;
    r.secs    = secs[rsait_pkg::SEC_W-1:0];
    r.presses = press_count;
    return r;
  endfunction

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    timer_report_t exp_r;
    timer_report_t act_r;
    if (!rst_n) begin
      active_dur  <= rsait_pkg::ACTIVE_DUR_RST;
      idle_dur    <= rsait_pkg::IDLE_DUR_RST;
      start_lock  <= rsait_pkg::START_LOCK_RST;
      press_lock  <= rsait_pkg::PRESS_LOCK_RST;
      running     = 1'b0;
      idle        = 1'b0;
      led         = 1'b0;
      prev_level  = 1'b1;
      press_pend  = 1'b0;
      mode_ms     = '0;
      start_ms    = '0;
      press_ms    = '0;
      press_count = '0;
      expected_reports.delete();
    end else begin
      // register write transfer; only the low bits are kept
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (rsait_pkg::cfg_reg_t'(cfg_paddr[3:2]))
          rsait_pkg::REG_ACTIVE_DUR: active_dur <= cfg_pwdata[rsait_pkg::CFG_W-1:0];
          rsait_pkg::REG_IDLE_DUR:   idle_dur   <= cfg_pwdata[rsait_pkg::CFG_W-1:0];
          rsait_pkg::REG_START_LOCK: start_lock <= cfg_pwdata[rsait_pkg::CFG_W-1:0];
          rsait_pkg::REG_PRESS_LOCK: press_lock <= cfg_pwdata[rsait_pkg::CFG_W-1:0];
          default: ;
        endcase
      end
      // result transfer against the oldest prediction
      if (out_tvalid && out_tready) begin
        act_r = out_tdata[$bits(timer_report_t)-1:0];
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none, actual %h", $time, out_tdata);
          errors++;
        end else begin
          exp_r = expected_reports.pop_front();
          check_field("is_running", exp_r.run, act_r.run);
          check_field("mode_is_idle", exp_r.idle, act_r.idle);
          check_field("led_on", exp_r.led, act_r.led);
          check_field("remaining_seconds", exp_r.secs, act_r.secs);
          check_field("accepted_presses", exp_r.presses, act_r.presses);
        end
      end
      // tick transfer
      if (in_tvalid && in_tready)
        expected_reports.push_back(next_timer_report(in_tdata[0], in_tdata[1]));
    end
    queued = expected_reports.size();
  end

endmodule

@@ tb/tb_run_stop_active_idle_mode_timer_top.sv @@
// Testbench top for the run/stop timer: clock, reset, tick and register stimulus, verdict.
`timescale 1ns / 1ps

module tb_run_stop_active_idle_mode_timer_top;

  localparam logic [rsait_pkg::CFG_W-1:0] MS_HIGH = 21'd2000000;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [rsait_pkg::IN_W-1:0]   in_tdata = '0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [rsait_pkg::OUT_W-1:0]  out_tdata;
  logic                         cfg_psel = 1'b0;
  logic                         cfg_penable = 1'b0;
  logic                         cfg_pwrite = 1'b0;
  logic [rsait_pkg::ADDR_W-1:0] cfg_paddr = '0;
  logic [rsait_pkg::DATA_W-1:0] cfg_pwdata = '0;
  logic [rsait_pkg::DATA_W-1:0] cfg_prdata;
  logic                         cfg_pready;

  int errors;
  int queued;
  int send_gap_pct = 0;
  int sink_gap_pct = 0;

  run_stop_active_idle_mode_timer_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  run_stop_active_idle_mode_timer_checker scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .errors      (errors),
    .queued      (queued)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver stalls
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_gap_pct);
  end

  // Hard stop if the block hangs
  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // One APB write; psel stays up so back-to-back writes chain
  task automatic write_cfg(input rsait_pkg::cfg_reg_t idx,
                           input logic [rsait_pkg::CFG_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    // junk above bit 20 must be dropped
    cfg_pwdata  <= {11'($urandom_range(2047)), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
  endtask

  task automatic load_timing(input logic [rsait_pkg::CFG_W-1:0] act_ms,
                             input logic [rsait_pkg::CFG_W-1:0] idl_ms,
                             input logic [rsait_pkg::CFG_W-1:0] st_ms,
                             input logic [rsait_pkg::CFG_W-1:0] pr_ms);
    write_cfg(rsait_pkg::REG_ACTIVE_DUR, act_ms);
    write_cfg(rsait_pkg::REG_IDLE_DUR, idl_ms);
    write_cfg(rsait_pkg::REG_START_LOCK, st_ms);
    write_cfg(rsait_pkg::REG_PRESS_LOCK, pr_ms);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly small values so modes turn over, sometimes the extremes
  function automatic logic [rsait_pkg::CFG_W-1:0] pick_ms(input int unsigned span);
    case ($urandom_range(15))
      0:       return '0;
      1:       return rsait_pkg::CFG_W'(1);
      2:       return MS_HIGH;
      3:       return '1;
      default: return rsait_pkg::CFG_W'($urandom_range(span));
    endcase
  endfunction

  // One tick transfer, with random source gaps ahead of it
  task automatic send_tick(input logic lvl, input logic pe);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, pe, lvl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Button-like level: long released stretches, short presses, some glitches
  task automatic random_ticks(input int count);
    logic lvl;
    logic pe;
    int   low_left;
    low_left = 0;
    repeat (count) begin
      if (low_left > 0) begin
        lvl = 1'b0;
        low_left--;
      end else if ($urandom_range(99) < 4) begin
        lvl = 1'b0;
        low_left = $urandom_range(6);
      end else begin
        lvl = 1'b1;
      end
      if ($urandom_range(99) < 3) lvl = ~lvl;
      pe = ($urandom_range(99) < 25);
      send_tick(lvl, pe);
    end
  endtask

  // Drain all outstanding reports, then let the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (queued != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_gap_pct = 22;
    sink_gap_pct = 48;

    // short modes, press lockout of one tick
    load_timing(21'd3, 21'd3, 21'd0, 21'd1);
    send_tick(1'b1, 1'b1);  // press inside lockout
    send_tick(1'b1, 1'b1);  // press while stopped
    send_tick(1'b0, 1'b0);  // start
    send_tick(1'b0, 1'b1);  // press in active
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);  // press on the tick idle begins
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);  // press held over idle
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);  // stop
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);  // start again
    settle();

    // zero durations: mode flips every running tick
    load_timing('0, '0, '0, '0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    settle();

    // huge durations, press lockout at counter max
    load_timing('1, MS_HIGH, '0, '1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    settle();

    // random ticks over three flow-control regimes
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_gap_pct = 22;
          sink_gap_pct = 48;
        end
        1: begin
          send_gap_pct = 48;
          sink_gap_pct = 22;
        end
        default: begin
          send_gap_pct = 0;
          sink_gap_pct = 0;
        end
      endcase
      for (int s = 0; s < 4; s++) begin
        if (ph == 1 && s == 3)
          load_timing(rsait_pkg::ACTIVE_DUR_RST, rsait_pkg::IDLE_DUR_RST,
                      rsait_pkg::START_LOCK_RST, rsait_pkg::PRESS_LOCK_RST);
        else
          load_timing(pick_ms(40), pick_ms(40), pick_ms(25), pick_ms(12));
        random_ticks(170);
        settle();
      end
    end

    repeat (8) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/rsait_pkg.sv
rtl/core/run_stop_active_idle_mode_timer_top.sv
tb/run_stop_active_idle_mode_timer_checker.sv
tb/tb_run_stop_active_idle_mode_timer_top.sv
